FILE: rtl/core/crc_checked_frame_deframer_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame deframer
// Shared clocked property wrappers used by the RTL files.
// ----------------------------------------------------------------------------
`ifndef CRC_CHECKED_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define CRC_CHECKED_FRAME_DEFRAMER_UNIT_MACROS_SVH

// Implication checked at every clock edge outside reset
`define CFD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define CFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/cfd_pkg.sv
// ----------------------------------------------------------------------------
// Frame deframer package
// Types, constants and the bytewise CRC-32C function.
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam int unsigned LenBitsDefault = 16;
  localparam int unsigned HeaderBytes    = 28;
  localparam int unsigned TrailerBytes   = 4;
  localparam int unsigned HdrCrcSpan     = HeaderBytes - 4;
  localparam logic [31:0] CrcPoly        = 32'h82F6_3B78;
  localparam logic [31:0] CrcInit        = 32'hFFFF_FFFF;
  localparam logic [31:0] MagicWord      = {8'h53, 8'h52, 8'h46, 8'h57};
  localparam logic [15:0] MsgIdMax       = 16'd16;
  localparam int unsigned QueueDepth     = 2;

  typedef enum logic [1:0] {
    CFG_EXPECTED_VERSION = 2'd0,
    CFG_MAX_PAYLOAD      = 2'd1,
    CFG_BIG_ENDIAN       = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_END     = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_MAGIC   = 3'd1,
    ST_HDR_CRC = 3'd2,
    ST_VERSION = 3'd3,
    ST_FLAGS   = 3'd4,
    ST_MSG_ID  = 3'd5,
    ST_LENGTH  = 3'd6,
    ST_PAY_CRC = 3'd7
  } status_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  message_id;
    logic [63:0] req_tag;
    logic [15:0] frame_len;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic        last;
  } out_item_t;

  // Advance CRC-32C (reflected) by one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // Reverse bytes of a 32-bit word
  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

FILE: rtl/core/cfd_front.sv
// ----------------------------------------------------------------------------
// Frame deframer front end
// Parses header, payload and trailer bytes and emits classified results.
// ----------------------------------------------------------------------------
module cfd_front #(
  parameter int unsigned LenBits = cfd_pkg::LenBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  cfd_pkg::in_item_t    in_item_i,
  input  logic [15:0]          expected_version_i,
  input  logic [15:0]          max_payload_i,
  input  logic                 big_endian_i,
  output logic                 res_valid_o,
  output cfd_pkg::out_item_t   res_item_o
);
  import cfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_TRAILER = 3'b100
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] count_q, count_d;
  logic [31:0] crc_q, crc_d;
  logic [15:0] dlen_q, dlen_d;
  logic [31:0] trl_q, trl_d;
  logic        stuck_q, stuck_d;
  logic [7:0]  hdr_q [HeaderBytes];

  logic [7:0]  b;
  logic [4:0]  hidx;
  logic [7:0]  hb [HeaderBytes];
  logic [31:0] f_len, f_hcrc, got;
  logic [15:0] f_ver, f_msg, f_flags, f_rsvd;
  logic [63:0] f_rid;
  logic [31:0] hcrc;
  logic [15:0] cnt_inc;
  logic [31:0] trl_shift;
  status_e     st;

  assign b         = in_item_i.data_byte;
  assign hidx      = count_q[4:0];
  assign cnt_inc   = count_q + 16'd1;
  assign trl_shift = {trl_q[23:0], b};

  // View of header bytes including the one arriving now
  always_comb begin
    for (int i = 0; i < HeaderBytes; i++) begin
      hb[i] = (i == HeaderBytes - 1) ? b : hdr_q[i];
    end
  end

  // Decode header fields in the configured byte order
  always_comb begin
    if (big_endian_i) begin
      f_ver   = {hb[4], hb[5]};
      f_msg   = {hb[6], hb[7]};
      f_flags = {hb[8], hb[9]};
      f_rsvd  = {hb[10], hb[11]};
      f_len   = {hb[12], hb[13], hb[14], hb[15]};
      f_rid   = {hb[16], hb[17], hb[18], hb[19], hb[20], hb[21], hb[22], hb[23]};
      f_hcrc  = {hb[24], hb[25], hb[26], hb[27]};
      got     = trl_shift;
    end else begin
      f_ver   = {hb[5], hb[4]};
      f_msg   = {hb[7], hb[6]};
      f_flags = {hb[9], hb[8]};
      f_rsvd  = {hb[11], hb[10]};
      f_len   = {hb[15], hb[14], hb[13], hb[12]};
      f_rid   = {hb[23], hb[22], hb[21], hb[20], hb[19], hb[18], hb[17], hb[16]};
      f_hcrc  = {hb[27], hb[26], hb[25], hb[24]};
      got     = swap32(trl_shift);
    end
  end

  assign hcrc = ~crc_q;

  // Header checks in priority order
  always_comb begin
    logic over;
    over = (f_len > {16'd0, max_payload_i});
    if (LenBits < 32) over = over || ((f_len >> LenBits) != 32'd0);
    if (over)                                        st = ST_LENGTH;
    else if ({hb[0], hb[1], hb[2], hb[3]} != MagicWord) st = ST_MAGIC;
    else if (f_hcrc != hcrc)                         st = ST_HDR_CRC;
    else if (f_ver != expected_version_i)            st = ST_VERSION;
    else if (f_rsvd != 16'd0 || f_flags != 16'd0)    st = ST_FLAGS;
    else if (f_msg == 16'd0 || f_msg > MsgIdMax)     st = ST_MSG_ID;
    else                                             st = ST_OK;
  end

  // Next state and result
  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    crc_d       = crc_q;
    dlen_d      = dlen_q;
    trl_d       = trl_shift;
    stuck_d     = stuck_q;
    res_valid_o = 1'b0;
    res_item_o  = '0;
    if (!in_valid_i) begin
      trl_d = trl_q;
    end else if (in_item_i.mode) begin
      phase_d = PH_HEADER;
      count_d = '0;
      crc_d   = CrcInit;
      dlen_d  = '0;
      trl_d   = '0;
      stuck_d = 1'b0;
    end else if (stuck_q) begin
      trl_d = trl_q;
    end else begin
      unique case (phase_q)
        PH_PAYLOAD: begin
          trl_d   = trl_q;
          crc_d   = crc_byte(crc_q, b);
          count_d = cnt_inc;
          if (cnt_inc >= dlen_q) begin
            phase_d = PH_TRAILER;
            count_d = '0;
            trl_d   = '0;
          end
          res_valid_o             = 1'b1;
          res_item_o.kind         = KIND_PAYLOAD;
          res_item_o.payload_byte = b;
        end
        PH_TRAILER: begin
          count_d = cnt_inc;
          if (cnt_inc >= 16'(TrailerBytes)) begin
            phase_d           = PH_HEADER;
            count_d           = '0;
            crc_d             = CrcInit;
            trl_d             = '0;
            res_valid_o       = 1'b1;
            res_item_o.kind   = KIND_END;
            res_item_o.last   = 1'b1;
            res_item_o.status = (got == ~crc_q) ? ST_OK : ST_PAY_CRC;
            if (got != ~crc_q) stuck_d = 1'b1;
          end
        end
        default: begin
          trl_d = trl_q;
          if (count_q < 16'(HdrCrcSpan)) crc_d = crc_byte(crc_q, b);
          count_d = cnt_inc;
          if (cnt_inc >= 16'(HeaderBytes)) begin
            count_d     = '0;
            crc_d       = CrcInit;
            res_valid_o = 1'b1;
            if (st != ST_OK) begin
              stuck_d           = 1'b1;
              res_item_o.kind   = KIND_END;
              res_item_o.last   = 1'b1;
              res_item_o.status = st;
            end else begin
              dlen_d                = f_len[15:0];
              trl_d                 = '0;
              phase_d               = (f_len[15:0] == 16'd0) ? PH_TRAILER : PH_PAYLOAD;
              res_item_o.kind       = KIND_HEADER;
              res_item_o.message_id = f_msg[4:0];
              res_item_o.req_tag    = f_rid;
              res_item_o.frame_len  = f_len[15:0];
            end
          end
        end
      endcase
    end
  end

  // Capture header bytes
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_item_i.mode && !stuck_q && phase_q == PH_HEADER) begin
      hdr_q[hidx] <= b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      count_q <= '0;
      crc_q   <= CrcInit;
      dlen_q  <= '0;
      trl_q   <= '0;
      stuck_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      crc_q   <= crc_d;
      dlen_q  <= dlen_d;
      trl_q   <= trl_d;
      stuck_q <= stuck_d;
    end
  end

  `include "crc_checked_frame_deframer_unit_macros.svh"

  `CFD_ASSERT_IMP(a_hdr_count, clk_i, rst_ni, phase_q == PH_HEADER, count_q < 16'(HeaderBytes), "header count out of range")
  `CFD_ASSERT_IMP(a_trl_count, clk_i, rst_ni, phase_q == PH_TRAILER, count_q < 16'(TrailerBytes), "trailer count out of range")
  `CFD_ASSERT_IMP(a_stuck_quiet, clk_i, rst_ni, stuck_q && !(in_valid_i && in_item_i.mode), !res_valid_o, "result while stuck")

endmodule

FILE: rtl/core/cfd_queue.sv
// ----------------------------------------------------------------------------
// Frame deframer result queue
// Small FIFO between the parser and the result port.
// ----------------------------------------------------------------------------
module cfd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  cfd_pkg::out_item_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output cfd_pkg::out_item_t data_o
);
  import cfd_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  out_item_t       mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end
  end

  `include "crc_checked_frame_deframer_unit_macros.svh"

  `CFD_ASSERT_IMP(a_q_bound, clk_i, rst_ni, 1'b1, cnt_q <= (PtrW+1)'(QueueDepth), "queue count overflow")
  `CFD_ASSERT_NEXT(a_q_grow, clk_i, rst_ni, do_push && !do_pop, cnt_q == $past(cnt_q) + 1'b1, "queue count did not grow")
  `CFD_ASSERT_NEXT(a_q_shrink, clk_i, rst_ni, do_pop && !do_push, cnt_q == $past(cnt_q) - 1'b1, "queue count did not shrink")

endmodule

FILE: rtl/core/crc_checked_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// CRC checked frame deframer
// Parses length-prefixed frames with CRC-32C header and payload checks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: push with in_item_i (mode, data_byte); transfer when
//   push is high and full is low. mode 1 clears the stuck state.
//   Result channel: result_o is valid while empty is low; transfer when
//   pop is high. Kinds: header accepted, payload byte, frame end/error.
//   One byte is taken per cycle while full is low; the parser updates the
//   CRC-32C and header capture in the same cycle. A result enters the queue
//   at the edge its byte transfers and shows on result_o from the next
//   cycle, when it can transfer out. Throughput is one byte per cycle
//   while pop stays high.
//   A two-entry result queue separates parser and receiver: when the
//   receiver stalls, the queue fills and full holds off further bytes.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) apply from the
//   next byte. Reset clears the parser, the queue and sets register
//   defaults (version 1, limit 65535, little endian).
// ----------------------------------------------------------------------------
module crc_checked_frame_deframer_unit #(
  parameter int unsigned LenBits = cfd_pkg::LenBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  cfd_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output cfd_pkg::out_item_t result_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i
);
  import cfd_pkg::*;

  logic [15:0] ver_q, max_q;
  logic        be_q;
  logic        res_valid, accept;
  out_item_t   res_item;

  assign accept = push && !full;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ver_q <= 16'd1;
      max_q <= 16'hFFFF;
      be_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_EXPECTED_VERSION: ver_q <= cfg_wdata_i;
        CFG_MAX_PAYLOAD:      max_q <= cfg_wdata_i;
        CFG_BIG_ENDIAN:       be_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  cfd_front #(.LenBits(LenBits)) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (accept),
    .in_item_i          (in_item_i),
    .expected_version_i (ver_q),
    .max_payload_i      (max_q),
    .big_endian_i       (be_q),
    .res_valid_o        (res_valid),
    .res_item_o         (res_item)
  );

  cfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (result_o)
  );

endmodule
